FILE: hw/rtl/phpc_pkg.sv
// shared types and constants for the half-plane polygon clipper
package phpc_pkg;

   localparam int MAX_VERTICES     = 1024;
   localparam int COUNT_CAP        = (2 * MAX_VERTICES > 4095) ? 4095 : 2 * MAX_VERTICES;
   localparam int MIN_RESULT_VERTS = 3;
   localparam int CNT_W            = 12;
   localparam int DIV_STEPS        = 52;
   localparam int DIV_CNT_W        = 6;

   localparam logic [2:0] CSR_CUT_START_X = 3'd0;
   localparam logic [2:0] CSR_CUT_START_Y = 3'd1;
   localparam logic [2:0] CSR_CUT_END_X   = 3'd2;
   localparam logic [2:0] CSR_CUT_END_Y   = 3'd3;
   localparam logic [2:0] CSR_KEEP_LEFT   = 3'd4;
   localparam logic [2:0] CSR_TOLERANCE   = 3'd5;

   typedef struct packed {
      logic signed [15:0] cut_start_x;
      logic signed [15:0] cut_start_y;
      logic signed [15:0] cut_end_x;
      logic signed [15:0] cut_end_y;
      logic               keep_left;
      logic [19:0]        tolerance;
   } cfg_type;

   typedef struct packed {
      logic               req_type;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic               isect;
      logic               cin;
      logic               last;
   } item_type;

   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic               is_end_marker;
      logic [CNT_W-1:0]   vertex_count;
      logic               too_few;
      logic               end_of_run;
   } rsp_type;

endpackage

FILE: hw/rtl/phpc_front.sv
// front end: side test of each request against the cutter line and classification
module phpc_front (
   input  logic               clock,
   input  logic               reset,
   input  phpc_pkg::cfg_type  cfg,
   input  logic               push,
   output logic               full,
   input  logic               req_type,
   input  logic signed [15:0] vert_x,
   input  logic signed [15:0] vert_y,
   input  logic               last_vertex,
   output logic               q_push,
   input  logic               q_full,
   output phpc_pkg::item_type q_item
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_MUL  = 3'b010,
      F_CLS  = 3'b100
   } fstate_type;

   fstate_type state_ff, state_in;

   logic               rt_ff, last_ff;
   logic signed [15:0] cx_ff, cy_ff;
   logic signed [33:0] p1_ff, p2_ff;
   logic signed [15:0] prev_x_ff, prev_y_ff;
   logic signed [34:0] prev_side_ff;

   logic signed [16:0] dx, dy, qx, qy;
   logic signed [34:0] cs;
   logic               pin, cin;

   function automatic logic inside_f(input logic signed [34:0] sd, input logic kl,
                                     input logic [19:0] tol);
      logic signed [35:0] s;
      s = $signed({sd[34], sd}) + $signed({16'b0, tol});
      if (kl) inside_f = !s[35];
      else inside_f = (sd <= $signed({15'b0, tol}));
   endfunction

   assign dx = $signed({cfg.cut_end_x[15], cfg.cut_end_x})
             - $signed({cfg.cut_start_x[15], cfg.cut_start_x});
   assign dy = $signed({cfg.cut_end_y[15], cfg.cut_end_y})
             - $signed({cfg.cut_start_y[15], cfg.cut_start_y});
   assign qx = $signed({cx_ff[15], cx_ff}) - $signed({cfg.cut_start_x[15], cfg.cut_start_x});
   assign qy = $signed({cy_ff[15], cy_ff}) - $signed({cfg.cut_start_y[15], cfg.cut_start_y});
   assign cs = $signed({p1_ff[33], p1_ff}) - $signed({p2_ff[33], p2_ff});
   assign pin = inside_f(prev_side_ff, cfg.keep_left, cfg.tolerance);
   assign cin = inside_f(cs, cfg.keep_left, cfg.tolerance);

   assign full   = (state_ff != F_IDLE);
   assign q_push = (state_ff == F_CLS) && !q_full;

   always_comb begin
      q_item.req_type = rt_ff;
      q_item.cx       = cx_ff;
      q_item.cy       = cy_ff;
      q_item.px       = prev_x_ff;
      q_item.py       = prev_y_ff;
      q_item.isect    = (cin != pin);
      q_item.cin      = cin;
      q_item.last     = last_ff & rt_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: if (push) state_in = F_MUL;
         F_MUL: state_in = F_CLS;
         F_CLS: if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_side_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (q_push) begin
            prev_x_ff    <= cx_ff;
            prev_y_ff    <= cy_ff;
            prev_side_ff <= cs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && push) begin
         rt_ff   <= req_type;
         last_ff <= last_vertex;
         cx_ff   <= vert_x;
         cy_ff   <= vert_y;
      end
      if (state_ff == F_MUL) begin
         p1_ff <= dx * qy;
         p2_ff <= dy * qx;
      end
   end

endmodule

FILE: hw/rtl/phpc_queue.sv
// two-entry queue of classified requests between front and back
module phpc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  phpc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output phpc_pkg::item_type pop_item,
   output logic               empty
);

   phpc_pkg::item_type mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_item = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (push && !full) wptr_ff <= !wptr_ff;
         if (pop && !empty) rptr_ff <= !rptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push && !full} - {1'b0, pop && !empty};
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wptr_ff] <= push_item;
   end

endmodule

FILE: hw/rtl/phpc_back.sv
// back end: intersection with iterative divider, result emission and result queue
module phpc_back (
   input  logic               clock,
   input  logic               reset,
   input  phpc_pkg::cfg_type  cfg,
   input  logic               q_empty,
   input  phpc_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output phpc_pkg::rsp_type  rsp
);

   typedef enum logic [9:0] {
      B_IDLE   = 10'b0000000001,
      B_MUL1   = 10'b0000000010,
      B_MUL2   = 10'b0000000100,
      B_MUL3   = 10'b0000001000,
      B_MUL4   = 10'b0000010000,
      B_DIV    = 10'b0000100000,
      B_FIX    = 10'b0001000000,
      B_EMIT_I = 10'b0010000000,
      B_EMIT_V = 10'b0100000000,
      B_EMIT_E = 10'b1000000000
   } bstate_type;

   bstate_type state_ff, state_in;
   phpc_pkg::item_type it_ff;

   logic signed [33:0] ma_ff, mb_ff, mc_ff, md_ff;
   logic signed [34:0] den_ff, num_ff;
   logic signed [35:0] pxl_ff, pyl_ff;
   logic signed [33:0] pxh_ff, pyh_ff;
   logic [51:0] dvx_ff, dvy_ff;
   logic [34:0] remx_ff, remy_ff, dvr_ff;
   logic        negx_ff, negy_ff;
   logic [phpc_pkg::DIV_CNT_W-1:0] dcnt_ff;
   logic signed [15:0] ix_ff, iy_ff;
   logic [phpc_pkg::CNT_W-1:0] count_ff;

   phpc_pkg::rsp_type omem_ff [4];
   logic [1:0] owp_ff, orp_ff;
   logic [2:0] ocnt_ff;
   logic       owr;
   phpc_pkg::rsp_type owdata;

   logic signed [16:0] rx, ry, sxv, syv, ax, ay;
   logic signed [34:0] dena, numa;
   logic [34:0] aden;
   logic        par;
   logic signed [51:0] prodx, prody;
   logic [35:0] tx, ty;
   logic        bx, by;

   function automatic logic signed [16:0] sub17(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
      sub17 = $signed({a[15], a}) - $signed({b[15], b});
   endfunction

   function automatic logic signed [15:0] fix16(input logic signed [15:0] p,
                                                input logic [51:0] q, input logic neg);
      logic signed [53:0] qs, s;
      qs = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
      s  = $signed({{38{p[15]}}, p}) + qs;
      if (s > 54'sd32767) fix16 = 16'sh7fff;
      else if (s < -54'sd32768) fix16 = 16'sh8000;
      else fix16 = s[15:0];
   endfunction

   assign rx  = sub17(it_ff.cx, it_ff.px);
   assign ry  = sub17(it_ff.cy, it_ff.py);
   assign sxv = sub17(cfg.cut_end_x, cfg.cut_start_x);
   assign syv = sub17(cfg.cut_end_y, cfg.cut_start_y);
   assign ax  = sub17(cfg.cut_start_x, it_ff.px);
   assign ay  = sub17(cfg.cut_start_y, it_ff.py);
   assign dena = $signed({ma_ff[33], ma_ff}) - $signed({mb_ff[33], mb_ff});
   assign numa = $signed({mc_ff[33], mc_ff}) - $signed({md_ff[33], md_ff});
   assign aden = den_ff[34] ? 35'(-den_ff) : den_ff;
   assign par  = (aden <= {15'b0, cfg.tolerance});
   assign prodx = $signed({pxh_ff, 18'b0}) + $signed({{16{pxl_ff[35]}}, pxl_ff});
   assign prody = $signed({pyh_ff, 18'b0}) + $signed({{16{pyl_ff[35]}}, pyl_ff});
   assign tx = {remx_ff, dvx_ff[51]};
   assign ty = {remy_ff, dvy_ff[51]};
   assign bx = (tx >= {1'b0, dvr_ff});
   assign by = (ty >= {1'b0, dvr_ff});

   assign q_pop     = (state_ff == B_IDLE) && !q_empty && (ocnt_ff <= 3'd1);
   assign rsp_empty = (ocnt_ff == 3'd0);
   assign rsp       = omem_ff[orp_ff];

   always_comb begin
      owr    = 1'b0;
      owdata = '0;
      case (state_ff)
         B_EMIT_I: begin
            owr = 1'b1;
            owdata.out_x = ix_ff;
            owdata.out_y = iy_ff;
            owdata.end_of_run = !it_ff.cin && !it_ff.last;
         end
         B_EMIT_V: begin
            owr = 1'b1;
            owdata.out_x = it_ff.cx;
            owdata.out_y = it_ff.cy;
            owdata.end_of_run = !it_ff.last;
         end
         B_EMIT_E: begin
            owr = 1'b1;
            owdata.is_end_marker = 1'b1;
            owdata.vertex_count  = count_ff;
            owdata.too_few = (count_ff < phpc_pkg::CNT_W'(phpc_pkg::MIN_RESULT_VERTS));
            owdata.end_of_run = 1'b1;
         end
         default: owr = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_pop) begin
               if (!q_item.req_type) state_in = B_IDLE;
               else if (q_item.isect) state_in = B_MUL1;
               else if (q_item.cin) state_in = B_EMIT_V;
               else if (q_item.last) state_in = B_EMIT_E;
            end
         end
         B_MUL1: state_in = B_MUL2;
         B_MUL2: state_in = B_MUL3;
         B_MUL3: state_in = par ? B_EMIT_I : B_MUL4;
         B_MUL4: state_in = B_DIV;
         B_DIV: if (dcnt_ff == phpc_pkg::DIV_CNT_W'(phpc_pkg::DIV_STEPS - 1)) state_in = B_FIX;
         B_FIX: state_in = B_EMIT_I;
         B_EMIT_I: begin
            if (it_ff.cin) state_in = B_EMIT_V;
            else if (it_ff.last) state_in = B_EMIT_E;
            else state_in = B_IDLE;
         end
         B_EMIT_V: state_in = it_ff.last ? B_EMIT_E : B_IDLE;
         B_EMIT_E: state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         count_ff <= '0;
         owp_ff   <= '0;
         orp_ff   <= '0;
         ocnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (q_pop && !q_item.req_type) count_ff <= '0;
         else if (state_ff == B_EMIT_E) count_ff <= '0;
         else if ((state_ff == B_EMIT_I || state_ff == B_EMIT_V)
                  && count_ff < phpc_pkg::CNT_W'(phpc_pkg::COUNT_CAP))
            count_ff <= count_ff + 1'b1;
         if (owr) owp_ff <= owp_ff + 1'b1;
         if (rsp_pop && !rsp_empty) orp_ff <= orp_ff + 1'b1;
         ocnt_ff <= ocnt_ff + {2'b0, owr} - {2'b0, rsp_pop && !rsp_empty};
      end
   end

   always_ff @(posedge clock) begin
      if (owr) omem_ff[owp_ff] <= owdata;
      if (q_pop) it_ff <= q_item;
      case (state_ff)
         B_MUL1: begin
            ma_ff <= rx * syv;
            mb_ff <= ry * sxv;
            mc_ff <= ax * syv;
            md_ff <= ay * sxv;
         end
         B_MUL2: begin
            den_ff <= dena;
            num_ff <= numa;
         end
         B_MUL3: begin
            ix_ff  <= it_ff.cx;
            iy_ff  <= it_ff.cy;
            pxl_ff <= rx * $signed({1'b0, num_ff[17:0]});
            pyl_ff <= ry * $signed({1'b0, num_ff[17:0]});
            pxh_ff <= rx * $signed(num_ff[34:18]);
            pyh_ff <= ry * $signed(num_ff[34:18]);
         end
         B_MUL4: begin
            dvx_ff  <= prodx[51] ? 52'(-prodx) : prodx;
            dvy_ff  <= prody[51] ? 52'(-prody) : prody;
            negx_ff <= prodx[51] ^ den_ff[34];
            negy_ff <= prody[51] ^ den_ff[34];
            dvr_ff  <= aden;
            remx_ff <= '0;
            remy_ff <= '0;
            dcnt_ff <= '0;
         end
         B_DIV: begin
            remx_ff <= bx ? 35'(tx - {1'b0, dvr_ff}) : tx[34:0];
            remy_ff <= by ? 35'(ty - {1'b0, dvr_ff}) : ty[34:0];
            dvx_ff  <= {dvx_ff[50:0], bx};
            dvy_ff  <= {dvy_ff[50:0], by};
            dcnt_ff <= dcnt_ff + 1'b1;
         end
         B_FIX: begin
            ix_ff <= fix16(it_ff.px, dvx_ff, negx_ff);
            iy_ff <= fix16(it_ff.py, dvy_ff, negy_ff);
         end
         default: ;
      endcase
   end

endmodule

FILE: hw/rtl/polygon_half_plane_clipper.sv
// polygon clipper against one configured half-plane, top level
// front end takes a new request only once the last is classified and queued; a vertex with
// a crossing passes the multiply states and, unless its edge is parallel to the cutter
// within tolerance, the 52-step one-bit-per-cycle divider before it leaves the back end
// reset clears control, previous vertex, count and configuration registers to their defaults
module polygon_half_plane_clipper (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_type,
   input  logic signed [15:0] req_vert_x,
   input  logic signed [15:0] req_vert_y,
   input  logic               req_last_vertex,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic               rsp_is_end_marker,
   output logic [11:0]        rsp_vertex_count,
   output logic               rsp_too_few,
   output logic               rsp_end_of_run,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_wdata
);

   phpc_pkg::cfg_type  cfg_ff;
   phpc_pkg::item_type f_item, b_item;
   phpc_pkg::rsp_type  rsp;
   logic f_push, q_full, q_empty, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cut_start_x <= 16'sd0;
         cfg_ff.cut_start_y <= 16'sd0;
         cfg_ff.cut_end_x   <= 16'sd1;
         cfg_ff.cut_end_y   <= 16'sd0;
         cfg_ff.keep_left   <= 1'b1;
         cfg_ff.tolerance   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            phpc_pkg::CSR_CUT_START_X: cfg_ff.cut_start_x <= csr_wdata[15:0];
            phpc_pkg::CSR_CUT_START_Y: cfg_ff.cut_start_y <= csr_wdata[15:0];
            phpc_pkg::CSR_CUT_END_X:   cfg_ff.cut_end_x   <= csr_wdata[15:0];
            phpc_pkg::CSR_CUT_END_Y:   cfg_ff.cut_end_y   <= csr_wdata[15:0];
            phpc_pkg::CSR_KEEP_LEFT:   cfg_ff.keep_left   <= csr_wdata[0];
            phpc_pkg::CSR_TOLERANCE:   cfg_ff.tolerance   <= csr_wdata;
            default: ;
         endcase
      end
   end

   phpc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .push        (req_push),
      .full        (req_full),
      .req_type    (req_type),
      .vert_x      (req_vert_x),
      .vert_y      (req_vert_y),
      .last_vertex (req_last_vertex),
      .q_push      (f_push),
      .q_full      (q_full),
      .q_item      (f_item)
   );

   phpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_item (f_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (b_item),
      .empty     (q_empty)
   );

   phpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_item    (b_item),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_out_x         = rsp.out_x;
   assign rsp_out_y         = rsp.out_y;
   assign rsp_is_end_marker = rsp.is_end_marker;
   assign rsp_vertex_count  = rsp.vertex_count;
   assign rsp_too_few       = rsp.too_few;
   assign rsp_end_of_run    = rsp.end_of_run;

endmodule
